>>> sv/spr_pkg.sv
package spr_pkg;

  // input kinds carried on s_axis_tuser
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // field widths fixed by the stream format
  localparam int unsigned VTX_W    = 6;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned KIND_W   = 2;

  // saturation limits of a distance
  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // one stored edge, tail in the lowest bits
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [VTX_W-1:0]           head;
    logic [VTX_W-1:0]           tail;
  } edge_t;

  localparam int unsigned EDGE_W = $bits(edge_t);

endpackage

>>> sv/shortest_path_relaxation_core.sv
// load and clear words keep s_axis_tready high; a run holds it low until its last result
// word is loaded into the output register; a run makes at most n passes over the stored
// edges, the last one the cycle check, n the vertices in use; a live edge visits S_EDGE_RD,
// S_EDGE_DEC, S_DIST_B and S_RELAX: edge store read, tail and head distance reads through the
// single distance read port, then add, compare and write; a skipped edge stops at S_EDGE_DEC
// async active-low reset: edge count zero, num_vertices 64, no memory clearing pass
module shortest_path_relaxation_core
  import spr_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: num_vertices
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // edge_from[5:0], edge_to[11:6], edge_weight[27:12],
                                     // source_vertex[33:28], zero fill
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // vertex[5:0], distance[37:6], reachable[38], zero fill
  output logic [0:0]  m_axis_tuser,  // negative_cycle[0]
  output logic        m_axis_tlast   // last
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRC_INIT,
    S_EDGE_RD,
    S_EDGE_DEC,
    S_DIST_B,
    S_RELAX,
    S_PASS_END,
    S_CYCLE,
    S_OUT_RD,
    S_OUT_LD
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  num_vertices_q, num_vertices_d;
  logic [CW-1:0]     edge_count_q, edge_count_d;
  logic [CW-1:0]     eidx_q, eidx_d;
  logic [NW-1:0]     pass_q, pass_d;
  logic              probe_q, probe_d;
  logic              changed_q, changed_d;
  logic              found_q, found_d;
  logic [MAX_VERTICES-1:0] reached_q, reached_d;
  logic [VW-1:0]     head_q, head_d;
  logic signed [WEIGHT_W-1:0] weight_q, weight_d;
  logic signed [DIST_W-1:0]   dist_a_q, dist_a_d;
  logic [VW-1:0]     out_idx_q, out_idx_d;

  logic              m_valid_q, m_valid_d;
  logic [VTX_W-1:0]  m_vertex_q, m_vertex_d;
  logic signed [DIST_W-1:0] m_dist_q, m_dist_d;
  logic              m_reach_q, m_reach_d;
  logic              m_ncyc_q, m_ncyc_d;
  logic              m_last_q, m_last_d;

  // input word fields
  logic [KIND_W-1:0]          in_kind;
  logic [VTX_W-1:0]           in_from;
  logic [VTX_W-1:0]           in_to;
  logic signed [WEIGHT_W-1:0] in_weight;
  logic [VTX_W-1:0]           in_source;
  logic                       in_fire;

  assign in_kind   = s_axis_tuser;
  assign in_from   = s_axis_tdata[5:0];
  assign in_to     = s_axis_tdata[11:6];
  assign in_weight = s_axis_tdata[27:12];
  assign in_source = s_axis_tdata[33:28];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // vertices in use, clamped to one .. MAX_VERTICES
  logic [NW-1:0] n_eff;
  always_comb begin
    if (num_vertices_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_vertices_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(num_vertices_q);
    end
  end

  // edge store
  logic           edge_we;
  edge_t          edge_wdata;
  logic [EDGE_W-1:0] edge_rdata_raw;
  edge_t          edge_rd;

  assign edge_we    = in_fire && (in_kind == KIND_LOAD) && (32'(edge_count_q) < MAX_EDGES);
  assign edge_wdata = '{weight: in_weight, head: in_to, tail: in_from};
  assign edge_rd    = edge_t'(edge_rdata_raw);

  spr_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_count_q[EAW-1:0]),
    .wdata_i (EDGE_W'(edge_wdata)),
    .raddr_i (eidx_q[EAW-1:0]),
    .rdata_o (edge_rdata_raw)
  );

  // distance memory, one read address shared by tail, head and output reads
  logic              dist_we;
  logic [VW-1:0]     dist_raddr;
  logic [DIST_W-1:0] dist_rdata;
  logic signed [DIST_W-1:0] dist_wdata;

  always_comb begin
    unique case (state_q)
      S_EDGE_DEC: dist_raddr = VW'(edge_rd.tail);
      S_DIST_B:   dist_raddr = head_q;
      default:    dist_raddr = out_idx_q;
    endcase
  end

  spr_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (head_q),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // shared adder and compare: candidate through the edge, saturated
  logic signed [DIST_W:0] cand;
  logic                   do_relax;
  logic                   edge_live;
  logic                   slot_free;
  logic                   out_last;

  assign cand      = (DIST_W + 1)'(dist_a_q) + (DIST_W + 1)'(weight_q);
  assign do_relax  = !reached_q[head_q] || (cand < (DIST_W + 1)'($signed(dist_rdata)));
  assign edge_live = (32'(edge_rd.tail) < 32'(n_eff)) && (32'(edge_rd.head) < 32'(n_eff)) &&
                     reached_q[VW'(edge_rd.tail)];
  assign slot_free = !m_valid_q || m_axis_tready;
  assign out_last  = (NW'(out_idx_q) + NW'(1)) == n_eff;

  // source distance starts at zero, relaxed distances saturate
  always_comb begin
    if (state_q == S_SRC_INIT) begin
      dist_wdata = '0;
    end else if (cand[DIST_W] != cand[DIST_W-1]) begin
      dist_wdata = cand[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      dist_wdata = cand[DIST_W-1:0];
    end
  end

  assign dist_we = ((state_q == S_RELAX) && !probe_q && do_relax) ||
                   (state_q == S_SRC_INIT);

  // sequencer
  always_comb begin
    state_d        = state_q;
    num_vertices_d = num_vertices_q;
    edge_count_d   = edge_count_q;
    eidx_d         = eidx_q;
    pass_d         = pass_q;
    probe_d        = probe_q;
    changed_d      = changed_q;
    found_d        = found_q;
    reached_d      = reached_q;
    head_d         = head_q;
    weight_d       = weight_q;
    dist_a_d       = dist_a_q;
    out_idx_d      = out_idx_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    m_vertex_d     = m_vertex_q;
    m_dist_d       = m_dist_q;
    m_reach_d      = m_reach_q;
    m_ncyc_d       = m_ncyc_q;
    m_last_d       = m_last_q;

    if (cfg_valid_i) begin
      num_vertices_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_LOAD: begin
              if (edge_we) begin
                edge_count_d = edge_count_q + CW'(1);
              end
            end
            KIND_CLEAR: edge_count_d = '0;
            KIND_RUN: begin
              reached_d = '0;
              if (32'(in_source) < 32'(n_eff)) begin
                reached_d[VW'(in_source)] = 1'b1;
              end
              head_d    = VW'(in_source);
              eidx_d    = '0;
              pass_d    = NW'(1);
              probe_d   = (n_eff == NW'(1));
              changed_d = 1'b0;
              found_d   = 1'b0;
              state_d   = S_SRC_INIT;
            end
            default: ;
          endcase
        end
      end
      // zero distance written for the source
      S_SRC_INIT: begin
        state_d = S_EDGE_RD;
      end
      // read the next stored edge, or close the pass
      S_EDGE_RD: begin
        state_d = (eidx_q == edge_count_q) ? S_PASS_END : S_EDGE_DEC;
      end
      // edge word arrives; skip it or fetch the tail distance
      S_EDGE_DEC: begin
        head_d   = VW'(edge_rd.head);
        weight_d = edge_rd.weight;
        if (edge_live) begin
          state_d = S_DIST_B;
        end else begin
          eidx_d  = eidx_q + CW'(1);
          state_d = S_EDGE_RD;
        end
      end
      // tail distance arrives; fetch the head distance
      S_DIST_B: begin
        dist_a_d = dist_rdata;
        state_d  = S_RELAX;
      end
      // compare and relax
      S_RELAX: begin
        if (do_relax) begin
          if (probe_q) begin
            found_d = 1'b1;
          end else begin
            reached_d[head_q] = 1'b1;
            changed_d         = 1'b1;
          end
        end
        eidx_d  = eidx_q + CW'(1);
        state_d = S_EDGE_RD;
      end
      S_PASS_END: begin
        eidx_d = '0;
        if (probe_q) begin
          out_idx_d = '0;
          state_d   = found_q ? S_CYCLE : S_OUT_RD;
        end else if (!changed_q || (pass_q == n_eff - NW'(1))) begin
          probe_d = 1'b1;
          state_d = S_EDGE_RD;
        end else begin
          pass_d    = pass_q + NW'(1);
          changed_d = 1'b0;
          state_d   = S_EDGE_RD;
        end
      end
      // single negative cycle result
      S_CYCLE: begin
        if (slot_free) begin
          m_valid_d  = 1'b1;
          m_vertex_d = '0;
          m_dist_d   = '0;
          m_reach_d  = 1'b0;
          m_ncyc_d   = 1'b1;
          m_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      // distance read once the output register frees up
      S_OUT_RD: begin
        if (slot_free) begin
          state_d = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        m_valid_d  = 1'b1;
        m_vertex_d = VTX_W'(out_idx_q);
        m_dist_d   = reached_q[out_idx_q] ? $signed(dist_rdata) : '0;
        m_reach_d  = reached_q[out_idx_q];
        m_ncyc_d   = 1'b0;
        m_last_d   = out_last;
        if (out_last) begin
          state_d = S_IDLE;
        end else begin
          out_idx_d = out_idx_q + VW'(1);
          state_d   = S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      num_vertices_q <= CFG_W'(64);
      edge_count_q   <= '0;
      eidx_q         <= '0;
      pass_q         <= '0;
      probe_q        <= 1'b0;
      changed_q      <= 1'b0;
      found_q        <= 1'b0;
      reached_q      <= '0;
      head_q         <= '0;
      weight_q       <= '0;
      dist_a_q       <= '0;
      out_idx_q      <= '0;
      m_valid_q      <= 1'b0;
      m_vertex_q     <= '0;
      m_dist_q       <= '0;
      m_reach_q      <= 1'b0;
      m_ncyc_q       <= 1'b0;
      m_last_q       <= 1'b0;
    end else begin
      state_q        <= state_d;
      num_vertices_q <= num_vertices_d;
      edge_count_q   <= edge_count_d;
      eidx_q         <= eidx_d;
      pass_q         <= pass_d;
      probe_q        <= probe_d;
      changed_q      <= changed_d;
      found_q        <= found_d;
      reached_q      <= reached_d;
      head_q         <= head_d;
      weight_q       <= weight_d;
      dist_a_q       <= dist_a_d;
      out_idx_q      <= out_idx_d;
      m_valid_q      <= m_valid_d;
      m_vertex_q     <= m_vertex_d;
      m_dist_q       <= m_dist_d;
      m_reach_q      <= m_reach_d;
      m_ncyc_q       <= m_ncyc_d;
      m_last_q       <= m_last_d;
    end
  end

  // ports
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_reach_q, m_dist_q, m_vertex_q};
  assign m_axis_tuser  = m_ncyc_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // edge count never passes the store depth
  a_edge_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_count_q) <= MAX_EDGES)
    else $error("edge count beyond store depth");

  // the cycle check pass never changes a distance
  a_probe_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RELAX) && probe_q) |-> !dist_we)
    else $error("distance written during cycle check");

  // a cycle result is the only result of its run
  a_cycle_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_ncyc_q) |-> (m_last_q && !m_reach_q))
    else $error("negative cycle result not final");

  // a result word is loaded only into a free output register
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_LD) |-> !m_valid_q)
    else $error("result register overwritten");
`endif

endmodule

>>> sv/spr_ram.sv
module spr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/tb_shortest_path_relaxation_core.sv
module tb_shortest_path_relaxation_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  localparam int unsigned VERTEX_CAP   = 64;
  localparam int unsigned EDGE_CAP     = 256;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned RANDOM_WORDS = 80;

  // the one kind code the block has no use for
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]          kind;
    logic [VTX_W-1:0]           tail;
    logic [VTX_W-1:0]           head;
    logic signed [WEIGHT_W-1:0] weight;
    logic [VTX_W-1:0]           source;
  } cmd_word_t;

  typedef struct {
    logic [VTX_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     cycle;
    logic                     last;
  } dist_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // edge_from, edge_to, edge_weight, source_vertex, zero fill
  logic [1:0]  s_axis_tuser = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // vertex, distance, reachable, zero fill
  logic [0:0]  m_axis_tuser;       // negative_cycle
  logic        m_axis_tlast;

  shortest_path_relaxation_core #(
    .MAX_VERTICES(VERTEX_CAP),
    .MAX_EDGES   (EDGE_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // shadow of the block state
  logic [6:0]  nv_model = 7'd64;
  int unsigned edge_total = 0;
  int unsigned tail_mdl[EDGE_CAP];
  int unsigned head_mdl[EDGE_CAP];
  int          wt_mdl[EDGE_CAP];
  int          dist_mdl[VERTEX_CAP];
  bit          hit_mdl[VERTEX_CAP];

  cmd_word_t    outgoing_words[$];
  dist_report_t awaited_reports[$];
  cmd_word_t    word_on_bus;
  int unsigned  words_queued = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           no_gaps = 1'b0;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned active_vertices();
    if (nv_model == 0) return 1;
    if (nv_model > VERTEX_CAP) return VERTEX_CAP;
    return nv_model;
  endfunction

  // one pass over the stored edges; with probe_only set nothing is written
  function automatic bit relax_edges(int unsigned n, bit probe_only);
    longint      cand;
    int unsigned a;
    int unsigned b;
    bit          changed;
    changed = 1'b0;
    for (int unsigned e = 0; e < edge_total; e++) begin
      a = tail_mdl[e];
      b = head_mdl[e];
      if (a >= n || b >= n || !hit_mdl[a]) continue;
      cand = longint'(dist_mdl[a]) + longint'(wt_mdl[e]);
      if (!hit_mdl[b] || cand < longint'(dist_mdl[b])) begin
        if (probe_only) return 1'b1;
        if (cand > 64'sd2147483647) cand = 64'sd2147483647;
        if (cand < -64'sd2147483648) cand = -64'sd2147483648;
        dist_mdl[b] = int'(cand);
        hit_mdl[b]  = 1'b1;
        changed     = 1'b1;
      end
    end
    return changed;
  endfunction

  // update the shadow state for an accepted word and queue the reports it causes
  function automatic void apply_word(cmd_word_t w);
    int unsigned  n;
    dist_report_t r;
    case (w.kind)
      KIND_LOAD: begin
        if (edge_total < EDGE_CAP) begin
          tail_mdl[edge_total] = w.tail;
          head_mdl[edge_total] = w.head;
          wt_mdl[edge_total]   = int'(w.weight);
          edge_total++;
        end
      end
      KIND_CLEAR: edge_total = 0;
      KIND_RUN: begin
        n = active_vertices();
        for (int unsigned i = 0; i < VERTEX_CAP; i++) begin
          dist_mdl[i] = 0;
          hit_mdl[i]  = 1'b0;
        end
        if (w.source < n) hit_mdl[w.source] = 1'b1;
        for (int unsigned p = 1; p < n; p++) begin
          if (!relax_edges(n, 1'b0)) break;
        end
        if (relax_edges(n, 1'b1)) begin
          // reachable negative cycle: a single flagged report
          r.vertex    = '0;
          r.distance  = '0;
          r.reachable = 1'b0;
          r.cycle     = 1'b1;
          r.last      = 1'b1;
          awaited_reports.insert(awaited_reports.size(), r);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            r.vertex    = i[VTX_W-1:0];
            r.distance  = hit_mdl[i] ? dist_mdl[i] : 0;
            r.reachable = hit_mdl[i];
            r.cycle     = 1'b0;
            r.last      = (i + 1 == n);
            awaited_reports.insert(awaited_reports.size(), r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_word(word_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (outgoing_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 18)) begin
          word_on_bus = outgoing_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, word_on_bus.source, word_on_bus.weight,
                            word_on_bus.head, word_on_bus.tail};
          s_axis_tuser  <= word_on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    dist_report_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result word: vertex %0d", m_axis_tdata[5:0]);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("vertex", want.vertex, m_axis_tdata[5:0]);
          check_field("distance", want.distance, $signed(m_axis_tdata[37:6]));
          check_field("reachable", want.reachable, m_axis_tdata[38]);
          check_field("negative_cycle", want.cycle, m_axis_tuser[0]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 18);
    end
  end

  function automatic void add_word(logic [1:0] kind, int tail, int head, int weight,
                                   int source);
    cmd_word_t w;
    w.kind   = kind;
    w.tail   = tail[VTX_W-1:0];
    w.head   = head[VTX_W-1:0];
    w.weight = weight[WEIGHT_W-1:0];
    w.source = source[VTX_W-1:0];
    outgoing_words.insert(outgoing_words.size(), w);
    words_queued++;
  endfunction

  // unused fields carry random bits
  function automatic void add_edge(int tail, int head, int weight);
    add_word(KIND_LOAD, tail, head, weight, $urandom_range(0, 63));
  endfunction

  function automatic void add_run(int source);
    add_word(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, source);
  endfunction

  // wait until the block has nothing left to do
  task automatic settle();
    while (outgoing_words.size() != 0 || s_axis_tvalid || awaited_reports.size() != 0)
      @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(logic [6:0] value);
    settle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    nv_model = value;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned span;
    int unsigned mode;
    int unsigned first_random;
    int          wv;
    int unsigned seq;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value of the vertex count, empty store, unused kind
    add_run(0);
    add_word(KIND_SPARE, 63, 63, -1, 63);
    add_run(63);

    // a chain with extreme weights and edges leaving the vertices in use
    set_vertex_count(7'd4);
    add_edge(0, 1, 32767);
    add_edge(1, 2, -32768);
    add_edge(2, 3, 5);
    add_edge(3, 63, 7);
    add_edge(63, 0, -9);
    add_edge(0, 2, 100);
    add_run(0);
    add_run(2);
    add_run(63);

    // zero vertices acts as one, oversize acts as the full count
    set_vertex_count(7'd0);
    add_run(0);
    set_vertex_count(7'd127);
    add_run(3);

    // negative cycle reachable, then the same cycle out of reach
    add_word(KIND_CLEAR, 0, 0, 0, 0);
    add_edge(0, 1, -1);
    add_edge(1, 0, -1);
    add_run(0);
    add_run(5);

    // empty store and a small graph for the random phase
    set_vertex_count(7'd8);
    add_word(KIND_CLEAR, 0, 0, 0, 0);

    // random phase: mostly load sequences followed by runs, some noise
    first_random = words_queued;
    seq = 0;
    while (words_queued - first_random < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) == 0)
        set_vertex_count(($urandom_range(0, 5) == 0) ? 7'd64 : 7'($urandom_range(2, 12)));
      span = active_vertices();
      no_gaps = (seq == 3 || seq == 4);
      mode = $urandom_range(0, 9);
      if (mode < 8) begin
        if (mode != 6) add_word(KIND_CLEAR, $urandom_range(0, 63), 0, $urandom, 0);
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 3) == 0) wv = -int'($urandom_range(0, 20));
          else wv = $urandom_range(0, 200);
          add_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1), wv);
        end
        repeat ($urandom_range(1, 2)) add_run($urandom_range(0, span - 1));
      end else begin
        repeat (6)
          add_word($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom, $urandom_range(0, 63));
      end
      // drain everything queued so far with both sides streaming without gaps
      if (seq == 4) settle();
      seq++;
    end
    no_gaps = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
